// ----- rtl/esq_pkg.sv -----
package esq_pkg;

  // Command bytes of the serial flash.
  localparam logic [7:0] OpRdsr = 8'h05;
  localparam logic [7:0] OpWren = 8'h06;
  localparam logic [7:0] OpSe   = 8'h20;
  localparam logic [7:0] OpBe   = 8'hD8;

  // Bit positions in status register 1.
  localparam int unsigned StBusyBit = 0;
  localparam int unsigned StWelBit  = 1;

  // Busy polling interval in millisecond ticks.
  localparam logic [3:0] PollMs = 4'd10;

  // Configuration register indexes.
  localparam logic [1:0] CfgReady  = 2'd0;
  localparam logic [1:0] CfgSector = 2'd1;
  localparam logic [1:0] CfgBlock  = 2'd2;
  localparam logic [1:0] CfgWel    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [15:0] SectorBudgetRst = 16'd1000;
  localparam logic [15:0] BlockBudgetRst  = 16'd3000;
  localparam logic [2:0]  WelAttemptsRst  = 3'd3;

  typedef enum logic [2:0] {
    MODE_START_SECTOR = 3'd0,
    MODE_START_BLOCK  = 3'd1,
    MODE_STATUS       = 3'd2,
    MODE_TICK         = 3'd3,
    MODE_SEND_FAIL    = 3'd4
  } esq_mode_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_PRE_STAT   = 4'd1,
    PH_PRE_TICK   = 4'd2,
    PH_WE_TICK    = 4'd3,
    PH_WE_STAT    = 4'd4,
    PH_RETRY_TICK = 4'd5,
    PH_SENT_STAT  = 4'd6,
    PH_POLL_TICK  = 4'd7,
    PH_POLL_STAT  = 4'd8
  } esq_phase_e;

  typedef enum logic [1:0] {
    ISSUE_NONE  = 2'd0,
    ISSUE_RDSR  = 2'd1,
    ISSUE_WREN  = 2'd2,
    ISSUE_ERASE = 2'd3
  } esq_issue_e;

  typedef enum logic [1:0] {
    OUTC_OK      = 2'd0,
    OUTC_ERROR   = 2'd1,
    OUTC_TIMEOUT = 2'd2
  } esq_outcome_e;

  // Sequencer state carried from one item to the next.
  typedef struct packed {
    esq_phase_e  phase;
    logic [3:0]  wait_ticks;
    logic [2:0]  attempts_left;
    logic [15:0] budget_left;
    logic        is_block;
    logic [31:0] target_address;
  } esq_state_t;

  // Configuration register contents.
  typedef struct packed {
    logic        ready;
    logic [15:0] sector_budget_ms;
    logic [15:0] block_budget_ms;
    logic [2:0]  wel_attempts;
  } esq_cfg_t;

  // One result item.
  typedef struct packed {
    esq_issue_e   issue;
    logic [7:0]   opcode;
    logic [31:0]  erase_address;
    logic         done_res;
    esq_outcome_e outcome;
  } esq_res_t;

endpackage

// ----- rtl/esq_step.sv -----
module esq_step (
  input  esq_pkg::esq_state_t state_i,
  input  esq_pkg::esq_cfg_t   cfg_i,
  input  logic [2:0]          mode_i,
  input  logic [31:0]         address_i,
  input  logic [7:0]          status_byte_i,
  output esq_pkg::esq_state_t state_o,
  output logic                res_valid_o,
  output esq_pkg::esq_res_t   res_o
);
  import esq_pkg::*;

  logic busy;
  logic wel;

  assign busy = status_byte_i[StBusyBit];
  assign wel  = status_byte_i[StWelBit];

  // One event against the current state: next state and at most one result.
  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (esq_mode_e'(mode_i))
      MODE_START_SECTOR, MODE_START_BLOCK: begin
        if (state_i.phase == PH_IDLE) begin
          res_valid_o = 1'b1;
          if (!cfg_i.ready) begin
            res_o.done_res = 1'b1;
            res_o.outcome  = OUTC_ERROR;
          end else begin
            state_o.target_address = address_i;
            state_o.is_block       = mode_i[0];
            state_o.phase          = PH_PRE_STAT;
            res_o.issue            = ISSUE_RDSR;
            res_o.opcode           = OpRdsr;
          end
        end
      end
      MODE_STATUS: begin
        unique case (state_i.phase)
          PH_PRE_STAT: begin
            if (busy) begin
              state_o.phase = PH_PRE_TICK;
            end else begin
              state_o.attempts_left = cfg_i.wel_attempts;
              res_valid_o           = 1'b1;
              if (cfg_i.wel_attempts == '0) begin
                state_o.phase  = PH_IDLE;
                res_o.done_res = 1'b1;
                res_o.outcome  = OUTC_ERROR;
              end else begin
                state_o.phase = PH_WE_TICK;
                res_o.issue   = ISSUE_WREN;
                res_o.opcode  = OpWren;
              end
            end
          end
          PH_WE_STAT: begin
            if (wel) begin
              state_o.budget_left = state_i.is_block ? cfg_i.block_budget_ms
                                                     : cfg_i.sector_budget_ms;
              state_o.phase       = PH_SENT_STAT;
              res_valid_o         = 1'b1;
              res_o.issue         = ISSUE_ERASE;
              res_o.opcode        = state_i.is_block ? OpBe : OpSe;
              res_o.erase_address = state_i.target_address;
            end else begin
              state_o.attempts_left = state_i.attempts_left - 3'd1;
              state_o.phase         = PH_RETRY_TICK;
            end
          end
          PH_SENT_STAT, PH_POLL_STAT: begin
            if (busy && state_i.budget_left != '0) begin
              state_o.wait_ticks = PollMs;
              state_o.phase      = PH_POLL_TICK;
            end else begin
              state_o.phase  = PH_IDLE;
              res_valid_o    = 1'b1;
              res_o.done_res = 1'b1;
              res_o.outcome  = (state_i.budget_left == '0) ? OUTC_TIMEOUT : OUTC_OK;
            end
          end
          default: ;
        endcase
      end
      MODE_TICK: begin
        unique case (state_i.phase)
          PH_PRE_TICK: begin
            state_o.phase = PH_PRE_STAT;
            res_valid_o   = 1'b1;
            res_o.issue   = ISSUE_RDSR;
            res_o.opcode  = OpRdsr;
          end
          PH_WE_TICK: begin
            state_o.phase = PH_WE_STAT;
            res_valid_o   = 1'b1;
            res_o.issue   = ISSUE_RDSR;
            res_o.opcode  = OpRdsr;
          end
          PH_RETRY_TICK: begin
            res_valid_o = 1'b1;
            if (state_i.attempts_left == '0) begin
              state_o.phase  = PH_IDLE;
              res_o.done_res = 1'b1;
              res_o.outcome  = OUTC_ERROR;
            end else begin
              state_o.phase = PH_WE_TICK;
              res_o.issue   = ISSUE_WREN;
              res_o.opcode  = OpWren;
            end
          end
          PH_POLL_TICK: begin
            if (state_i.wait_ticks > 4'd1) begin
              state_o.wait_ticks = state_i.wait_ticks - 4'd1;
            end else begin
              state_o.wait_ticks  = '0;
              // The budget saturates at zero.
              state_o.budget_left = (state_i.budget_left > 16'(PollMs))
                                    ? state_i.budget_left - 16'(PollMs) : '0;
              state_o.phase       = PH_POLL_STAT;
              res_valid_o         = 1'b1;
              res_o.issue         = ISSUE_RDSR;
              res_o.opcode        = OpRdsr;
            end
          end
          default: ;
        endcase
      end
      MODE_SEND_FAIL: begin
        if (state_i.phase == PH_SENT_STAT) begin
          state_o.phase  = PH_IDLE;
          res_valid_o    = 1'b1;
          res_o.done_res = 1'b1;
          res_o.outcome  = OUTC_ERROR;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/spi_flash_erase_sequencer_top.sv -----
// Host-side erase sequencer for a serial NOR flash.
// Events arrive on the slave stream: tuser carries the event kind (start
// sector erase, start block erase, status byte, 1 ms tick, send failure),
// tdata the erase address and the status byte read back. Each event gives
// at most one transfer on the master stream: a command to issue (tuser
// bits 1:0) with its opcode and address, and on completion the done flag
// (tuser bit 2) with the outcome (ok, error or timeout) in tdata.
// An event is taken into an input register, evaluated combinationally
// against the sequencer state, and its result lands in an output
// register. One event can be accepted in every cycle unless the receiver
// stalls; events that give no result pass through freely.
// When the receiver stalls, the output register holds its result and the
// input register holds the next event; tready drops only when both are full.
// The configuration port writes the ready flag, the two polling budgets
// and the write enable attempt count; write it only while idle.
// Reset returns the sequencer to idle, empties both registers and loads
// the configuration defaults: not ready, budgets 1000 and 3000 ms, three
// write enable attempts.
module spi_flash_erase_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // address[31:0], status_byte[39:32]
  input  logic [2:0]  s_axis_tuser,   // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // opcode[7:0], erase_address[39:8],
                                      // outcome[41:40], zeros[47:42]
  output logic [2:0]  m_axis_tuser    // issue[1:0], done_res[2]
);
  import esq_pkg::*;

  esq_cfg_t   cfg_q, cfg_d;
  esq_state_t state_q, state_d;
  logic       in_valid_q, in_valid_d;
  logic [2:0] in_mode_q;
  logic [39:0] in_data_q;
  logic       out_valid_q, out_valid_d;
  esq_res_t   out_q;
  esq_res_t   res;
  logic       res_valid;
  logic       advance;
  logic       s_accept;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgReady:  cfg_d.ready            = cfg_data_i[0];
        CfgSector: cfg_d.sector_budget_ms = cfg_data_i;
        CfgBlock:  cfg_d.block_budget_ms  = cfg_data_i;
        CfgWel:    cfg_d.wel_attempts     = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  esq_step u_step (
    .state_i       (state_q),
    .cfg_i         (cfg_q),
    .mode_i        (in_mode_q),
    .address_i     (in_data_q[31:0]),
    .status_byte_i (in_data_q[39:32]),
    .state_o       (state_d),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // The held event is evaluated once its result has room to go.
  assign advance       = in_valid_q && (!res_valid || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ready            <= 1'b0;
      cfg_q.sector_budget_ms <= SectorBudgetRst;
      cfg_q.block_budget_ms  <= BlockBudgetRst;
      cfg_q.wel_attempts     <= WelAttemptsRst;
      state_q                <= '{phase: PH_IDLE, default: '0};
      in_valid_q             <= 1'b0;
      out_valid_q            <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers of the input and output stages.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_mode_q <= s_axis_tuser;
      in_data_q <= s_axis_tdata;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.outcome, out_q.erase_address, out_q.opcode};
  assign m_axis_tuser  = {out_q.done_res, out_q.issue};

endmodule

// ----- dv/spi_flash_erase_sequencer_top_tb.sv -----
module spi_flash_erase_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import esq_pkg::*;

  // Cycles without any transfer before the run is given up.
  localparam int StallLimit = 2000;
  // A mode code that the sequencer does not know.
  localparam logic [2:0] ModeUnused = 3'd7;
  // Length of the long receiver hold-off, in cycles.
  localparam int HoldOffCycles = 200;

  // One event as offered on the slave stream.
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] addr;
    logic [7:0]  st;
  } flash_event_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // address[31:0], status_byte[39:32]
  logic [2:0]  s_axis_tuser  = '0;   // mode[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // opcode[7:0], erase_address[39:8], outcome[41:40]
  logic [2:0]  m_axis_tuser;         // issue[1:0], done_res[2]

  flash_event_t event_q[$];
  esq_res_t     cmd_exp_q[$];

  // Shadow of the sequencer state and its configuration.
  esq_state_t seq_st;
  esq_cfg_t   cfg_copy;

  int  snd_idle_pct  = 31;
  int  rcv_idle_pct  = 60;
  int  rcv_hold_left = 0;
  int  mismatch_cnt  = 0;
  int  quiet_cycles  = 0;
  int  script_cnt    = 0;
  bit  in_taken      = 1'b0;

  spi_flash_erase_sequencer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic esq_res_t flash_cmd(esq_issue_e issue, logic [7:0] op, logic [31:0] a);
    esq_res_t r;
    r = '0;
    r.issue = issue;
    r.opcode = op;
    r.erase_address = a;
    return r;
  endfunction

  function automatic esq_res_t op_done(esq_outcome_e o);
    esq_res_t r;
    r = '0;
    r.done_res = 1'b1;
    r.outcome = o;
    return r;
  endfunction

  // Advance the shadow sequencer by one accepted event and record its command.
  task automatic advance_sequencer(input logic [2:0] mode, input logic [31:0] addr,
                                   input logic [7:0] st);
    esq_res_t r;
    bit       has_res;
    r = '0;
    has_res = 1'b0;
    case (mode)
      MODE_START_SECTOR, MODE_START_BLOCK: begin
        if (seq_st.phase == PH_IDLE) begin
          has_res = 1'b1;
          if (!cfg_copy.ready) begin
            r = op_done(OUTC_ERROR);
          end else begin
            seq_st.target_address = addr;
            seq_st.is_block = mode[0];
            r = flash_cmd(ISSUE_RDSR, OpRdsr, '0);
            seq_st.phase = PH_PRE_STAT;
          end
        end
      end
      MODE_STATUS: begin
        case (seq_st.phase)
          PH_PRE_STAT: begin
            if (st[StBusyBit]) begin
              seq_st.phase = PH_PRE_TICK;
            end else begin
              seq_st.attempts_left = cfg_copy.wel_attempts;
              has_res = 1'b1;
              if (seq_st.attempts_left == 0) begin
                r = op_done(OUTC_ERROR);
                seq_st.phase = PH_IDLE;
              end else begin
                r = flash_cmd(ISSUE_WREN, OpWren, '0);
                seq_st.phase = PH_WE_TICK;
              end
            end
          end
          PH_WE_STAT: begin
            if (st[StWelBit]) begin
              seq_st.budget_left = seq_st.is_block ? cfg_copy.block_budget_ms
                                                   : cfg_copy.sector_budget_ms;
              r = flash_cmd(ISSUE_ERASE, seq_st.is_block ? OpBe : OpSe,
                            seq_st.target_address);
              has_res = 1'b1;
              seq_st.phase = PH_SENT_STAT;
            end else begin
              seq_st.attempts_left = seq_st.attempts_left - 3'd1;
              seq_st.phase = PH_RETRY_TICK;
            end
          end
          PH_SENT_STAT, PH_POLL_STAT: begin
            if (st[StBusyBit] && seq_st.budget_left != 0) begin
              seq_st.wait_ticks = PollMs;
              seq_st.phase = PH_POLL_TICK;
            end else begin
              // An exhausted budget times out even when the device is free.
              r = op_done(seq_st.budget_left == 0 ? OUTC_TIMEOUT : OUTC_OK);
              has_res = 1'b1;
              seq_st.phase = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      MODE_TICK: begin
        case (seq_st.phase)
          PH_PRE_TICK: begin
            r = flash_cmd(ISSUE_RDSR, OpRdsr, '0);
            has_res = 1'b1;
            seq_st.phase = PH_PRE_STAT;
          end
          PH_WE_TICK: begin
            r = flash_cmd(ISSUE_RDSR, OpRdsr, '0);
            has_res = 1'b1;
            seq_st.phase = PH_WE_STAT;
          end
          PH_RETRY_TICK: begin
            has_res = 1'b1;
            if (seq_st.attempts_left == 0) begin
              r = op_done(OUTC_ERROR);
              seq_st.phase = PH_IDLE;
            end else begin
              r = flash_cmd(ISSUE_WREN, OpWren, '0);
              seq_st.phase = PH_WE_TICK;
            end
          end
          PH_POLL_TICK: begin
            if (seq_st.wait_ticks > 1) begin
              seq_st.wait_ticks = seq_st.wait_ticks - 4'd1;
            end else begin
              seq_st.wait_ticks = '0;
              seq_st.budget_left = (seq_st.budget_left > 16'(PollMs)) ?
                                   seq_st.budget_left - 16'(PollMs) : '0;
              r = flash_cmd(ISSUE_RDSR, OpRdsr, '0);
              has_res = 1'b1;
              seq_st.phase = PH_POLL_STAT;
            end
          end
          default: ;
        endcase
      end
      MODE_SEND_FAIL: begin
        // A send failure only counts right after the erase frame.
        if (seq_st.phase == PH_SENT_STAT) begin
          r = op_done(OUTC_ERROR);
          has_res = 1'b1;
          seq_st.phase = PH_IDLE;
        end
      end
      default: ;
    endcase
    if (has_res) cmd_exp_q.push_back(r);
  endtask

  // Sender: presents the next pending event, holding it until it is taken.
  always @(negedge clk_i) begin : event_driver
    flash_event_t ev;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (event_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        ev = event_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ev.st, ev.addr};
        s_axis_tuser  <= ev.mode;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, with an occasional long hold-off.
  always @(negedge clk_i) begin : cmd_receiver
    if (rcv_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      rcv_hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Monitor: checks each command transfer, predicts from each event transfer.
  always @(posedge clk_i) begin : stream_monitor
    esq_res_t got;
    esq_res_t want;
    bit       moved;
    in_taken = 1'b0;
    moved = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got = '0;
        got.issue = esq_issue_e'(m_axis_tuser[1:0]);
        got.done_res = m_axis_tuser[2];
        got.opcode = m_axis_tdata[7:0];
        got.erase_address = m_axis_tdata[39:8];
        got.outcome = esq_outcome_e'(m_axis_tdata[41:40]);
        if (cmd_exp_q.size() == 0) begin
          report_mismatch($sformatf("command transfer with nothing expected, tdata %h tuser %h",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = cmd_exp_q.pop_front();
          if (got.issue !== want.issue)
            report_mismatch($sformatf("issue %0d, want %0d", got.issue, want.issue));
          if (got.opcode !== want.opcode)
            report_mismatch($sformatf("opcode %h, want %h", got.opcode, want.opcode));
          if (got.erase_address !== want.erase_address)
            report_mismatch($sformatf("erase address %h, want %h",
                                      got.erase_address, want.erase_address));
          if (got.done_res !== want.done_res)
            report_mismatch($sformatf("done %b, want %b", got.done_res, want.done_res));
          if (got.outcome !== want.outcome)
            report_mismatch($sformatf("outcome %0d, want %0d", got.outcome, want.outcome));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        in_taken = 1'b1;
        advance_sequencer(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[39:32]);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("spi_flash_erase_sequencer_top_tb failed");
        $finish;
      end
    end
  end

  task automatic queue_event(input logic [2:0] mode, input logic [31:0] addr,
                             input logic [7:0] st);
    event_q.push_back('{mode, addr, st});
  endtask

  // A scripted event, now and then preceded by a random one.
  task automatic queue_script(input logic [2:0] mode, input logic [31:0] addr,
                              input logic [7:0] st);
    if ($urandom_range(0, 11) == 0)
      queue_event(3'($urandom_range(0, 7)), $urandom, 8'($urandom_range(0, 255)));
    queue_event(mode, addr, st);
    script_cnt++;
  endtask

  function automatic logic [7:0] rand_status(logic busy);
    logic [7:0] st;
    st = 8'($urandom_range(0, 255));
    st[StBusyBit] = busy;
    return st;
  endfunction

  // Wait until every offered event is taken and every command has arrived.
  task automatic wait_drained();
    while (event_q.size() != 0 || s_axis_tvalid || cmd_exp_q.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
  endtask

  // Bring the sequencer back to idle by answering whatever it waits for.
  task automatic settle_idle();
    wait_drained();
    while (seq_st.phase != PH_IDLE) begin
      case (seq_st.phase)
        PH_PRE_STAT, PH_WE_STAT, PH_SENT_STAT, PH_POLL_STAT:
          queue_event(MODE_STATUS, '0, 8'h00);
        default:
          queue_event(MODE_TICK, '0, 8'h00);
      endcase
      wait_drained();
    end
    repeat (4) @(posedge clk_i);
    #1;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      CfgReady:  cfg_copy.ready = val[0];
      CfgSector: cfg_copy.sector_budget_ms = val;
      CfgBlock:  cfg_copy.block_budget_ms = val;
      CfgWel:    cfg_copy.wel_attempts = val[2:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(input logic ready, input logic [15:0] sector,
                           input logic [15:0] block, input logic [2:0] wel);
    settle_idle();
    write_reg(CfgReady, 16'(ready));
    write_reg(CfgSector, sector);
    write_reg(CfgBlock, block);
    write_reg(CfgWel, 16'(wel));
    @(posedge clk_i);
    #1;
  endtask

  function automatic logic [15:0] pick_budget();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  // One erase as a well-behaved device would answer it, with random content.
  task automatic queue_erase_run();
    int          nbusy;
    int          nfail;
    int          npoll;
    int          att;
    logic [7:0]  st;
    logic [31:0] a;
    case ($urandom_range(0, 7))
      0:       a = '0;
      1:       a = '1;
      default: a = $urandom;
    endcase
    queue_script($urandom_range(0, 1) ? MODE_START_BLOCK : MODE_START_SECTOR, a,
                 rand_status($urandom_range(0, 1)));
    nbusy = $urandom_range(0, 2);
    repeat (nbusy) begin
      queue_script(MODE_STATUS, $urandom, rand_status(1'b1));
      queue_script(MODE_TICK, $urandom, rand_status($urandom_range(0, 1)));
    end
    queue_script(MODE_STATUS, $urandom, rand_status(1'b0));
    att = cfg_copy.wel_attempts;
    if (att == 0) return;
    nfail = ($urandom_range(0, 3) == 0) ? att : $urandom_range(0, att - 1);
    repeat (nfail) begin
      queue_script(MODE_TICK, $urandom, rand_status($urandom_range(0, 1)));
      st = 8'($urandom_range(0, 255));
      st[StWelBit] = 1'b0;
      queue_script(MODE_STATUS, $urandom, st);
      queue_script(MODE_TICK, $urandom, rand_status($urandom_range(0, 1)));
    end
    if (nfail == att) return;
    queue_script(MODE_TICK, $urandom, rand_status($urandom_range(0, 1)));
    st = 8'($urandom_range(0, 255));
    st[StWelBit] = 1'b1;
    queue_script(MODE_STATUS, $urandom, st);
    if ($urandom_range(0, 6) == 0) begin
      queue_script(MODE_SEND_FAIL, $urandom, rand_status($urandom_range(0, 1)));
      return;
    end
    npoll = $urandom_range(0, 3);
    repeat (npoll) begin
      queue_script(MODE_STATUS, $urandom, rand_status(1'b1));
      repeat (PollMs) queue_script(MODE_TICK, $urandom, rand_status($urandom_range(0, 1)));
    end
    queue_script(MODE_STATUS, $urandom, rand_status($urandom_range(0, 4) == 0));
  endtask

  initial begin : stimulus
    logic [2:0] wel;
    seq_st = '0;
    seq_st.phase = PH_IDLE;
    cfg_copy.ready = 1'b0;
    cfg_copy.sector_budget_ms = SectorBudgetRst;
    cfg_copy.block_budget_ms = BlockBudgetRst;
    cfg_copy.wel_attempts = WelAttemptsRst;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    #1;

    // Starts before the device is ready fail straight away.
    queue_event(MODE_START_SECTOR, 32'h0000_0000, 8'h00);
    queue_event(MODE_START_BLOCK, 32'hFFFF_FFFF, 8'hFF);

    configure(1'b1, 16'h0000, 16'hFFFF, 3'd1);
    // Events nobody waits for, and an unknown mode, are dropped.
    queue_event(MODE_TICK, 32'h1234_5678, 8'h00);
    queue_event(MODE_STATUS, 32'h0, 8'hFF);
    queue_event(MODE_SEND_FAIL, 32'h0, 8'h00);
    queue_event(ModeUnused, 32'hFFFF_FFFF, 8'hFF);
    // Sector erase with a busy device first, a start while busy, and a
    // zero budget that times out although the device is free.
    queue_event(MODE_START_SECTOR, 32'hFFFF_FFFF, 8'h00);
    queue_event(MODE_STATUS, 32'h0, 8'hFF);
    queue_event(MODE_START_BLOCK, 32'h0, 8'h00);
    queue_event(MODE_TICK, 32'h0, 8'h00);
    queue_event(MODE_STATUS, 32'h0, 8'h00);
    queue_event(MODE_TICK, 32'h0, 8'h00);
    queue_event(MODE_STATUS, 32'h0, 8'h02);
    queue_event(MODE_STATUS, 32'h0, 8'h00);
    // Block erase whose frame could not be sent.
    queue_event(MODE_START_BLOCK, 32'h0000_0000, 8'h00);
    queue_event(MODE_STATUS, 32'h0, 8'hFE);
    queue_event(MODE_TICK, 32'h0, 8'h00);
    queue_event(MODE_STATUS, 32'h0, 8'hFE);
    queue_event(MODE_SEND_FAIL, 32'h0, 8'h00);
    // The write enable latch never sets: one more tick, then an error.
    queue_event(MODE_START_SECTOR, 32'h5A5A_A5A5, 8'h00);
    queue_event(MODE_STATUS, 32'h0, 8'h00);
    queue_event(MODE_TICK, 32'h0, 8'h00);
    queue_event(MODE_STATUS, 32'h0, 8'hFD);
    queue_event(MODE_TICK, 32'h0, 8'h00);

    // No write enable attempts at all.
    configure(1'b1, 16'h0000, 16'hFFFF, 3'd0);
    queue_event(MODE_START_BLOCK, 32'hA5A5_5A5A, 8'h00);
    queue_event(MODE_STATUS, 32'h0, 8'h00);

    for (int regime = 0; regime < 3; regime++) begin
      settle_idle();
      case (regime)
        0: begin snd_idle_pct = 31; rcv_idle_pct = 60; end
        1: begin snd_idle_pct = 60; rcv_idle_pct = 31; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      if (regime == 0) begin
        // Not-ready starts each give a result, so a long receiver
        // hold-off fills the block and stalls its input.
        configure(1'b0, pick_budget(), pick_budget(), 3'd3);
        rcv_hold_left = HoldOffCycles;
        repeat (30)
          queue_event($urandom_range(0, 1) ? MODE_START_BLOCK : MODE_START_SECTOR,
                      $urandom, 8'($urandom_range(0, 255)));
      end
      for (int sub = 0; sub < 3; sub++) begin
        case (sub)
          0:       wel = 3'd1;
          1:       wel = 3'd7;
          default: wel = 3'($urandom_range(0, 7));
        endcase
        configure(1'b1, pick_budget(), pick_budget(), wel);
        script_cnt = 0;
        while (script_cnt < 75) queue_erase_run();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    #1;
    if (mismatch_cnt == 0 && cmd_exp_q.size() == 0) begin
      $display("spi_flash_erase_sequencer_top_tb passed");
    end else begin
      $display("spi_flash_erase_sequencer_top_tb failed");
    end
    $finish;
  end

endmodule

// ----- spi_flash_erase_sequencer_top.f -----
rtl/esq_pkg.sv
rtl/esq_step.sv
rtl/spi_flash_erase_sequencer_top.sv
dv/spi_flash_erase_sequencer_top_tb.sv
